>>> hw/rtl/band_interleave_corner_turn_top_defines.svh
// Assertion macros shared by the corner-turn buffer modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef BAND_INTERLEAVE_CORNER_TURN_TOP_DEFINES_SVH
`define BAND_INTERLEAVE_CORNER_TURN_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BICT_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("corner-turn assertion failed");

// Next-cycle implication, checked out of reset.
`define BICT_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("corner-turn assertion failed");

`endif

>>> hw/rtl/bict_pkg.sv
`timescale 1ns / 1ps

package bict_pkg;

  // Buffer geometry.
  localparam int unsigned BUF_BYTES = 65536;
  localparam int unsigned ADDR_W    = $clog2(BUF_BYTES);
  localparam int unsigned WPOS_W    = $clog2(BUF_BYTES) + 1;

  // Field and register widths.
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned BAND_W    = 5;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned POL_W     = 3;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned PIDX_W    = 2;
  localparam int unsigned BIDX_W    = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 13;

  // Address arithmetic widths.
  localparam int unsigned SPEC_W    = 15;
  localparam int unsigned PTERM_W   = 14;
  localparam int unsigned PBAND_W   = 27;
  localparam int unsigned SUM_W     = 31;

  // Count limits.
  localparam logic [BAND_W-1:0]  BAND_MAX  = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd4096;
  localparam logic [POL_W-1:0]   POL_MAX   = 3'd4;

  // Item commands.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAND_COUNT    = 3'd0,
    CFG_SPECTRA_COUNT = 3'd1,
    CFG_POL_COUNT     = 3'd2,
    CFG_CHAN_COUNT    = 3'd3
  } cfg_reg_e;

  // Sequencer states for one fetch.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_SUM,
    ST_READ,
    ST_OUT
  } ctrl_state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_en;
    logic fetch_en;
    logic mul1_en;
    logic mul2_en;
    logic mul3_en;
    logic sum_en;
    logic read_en;
    logic out_load;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic out_full;
  } dp_status_t;

  // A zero count acts as one; a count above the limit acts as the limit.
  function automatic logic [BAND_W-1:0] clamp_band(input logic [BAND_W-1:0] v);
    logic [BAND_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = BAND_W'(1);
    end else if (v > BAND_MAX) begin
      r = BAND_MAX;
    end
    return r;
  endfunction

  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = COUNT_W'(1);
    end else if (v > COUNT_MAX) begin
      r = COUNT_MAX;
    end
    return r;
  endfunction

  function automatic logic [POL_W-1:0] clamp_pol(input logic [POL_W-1:0] v);
    logic [POL_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = POL_W'(1);
    end else if (v > POL_MAX) begin
      r = POL_MAX;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/bict_if.sv
`timescale 1ns / 1ps

// Input channel: one load or fetch item per beat.
interface bict_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [bict_pkg::BYTE_W-1:0]   load_byte;

  modport source (output valid, output command, output load_byte, input ready);
  modport sink   (input valid, input command, input load_byte, output ready);
endinterface

// Output channel: one fetched byte per beat.
interface bict_out_if;
  logic                          valid;
  logic                          ready;
  logic [bict_pkg::BYTE_W-1:0]   out_byte;
  logic                          frame_last;
  logic                          overflow;

  modport source (output valid, output out_byte, output frame_last, output overflow,
                  input ready);
  modport sink   (input valid, input out_byte, input frame_last, input overflow,
                  output ready);
endinterface

// Configuration write channel.
interface bict_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bict_pkg::CFG_IDX_W-1:0]  index;
  logic [bict_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/bict_ram.sv
`timescale 1ns / 1ps

module bict_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/bict_ctrl.sv
`timescale 1ns / 1ps
`include "band_interleave_corner_turn_top_defines.svh"

module bict_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_command_i,
  output logic                 in_ready_o,
  input  bict_pkg::dp_status_t status_i,
  output bict_pkg::dp_cmd_t    cmd_o
);

  bict_pkg::ctrl_state_e state_q, state_d;
  logic                  in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bict_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      bict_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_command_i == bict_pkg::CMD_FETCH) begin
            cmd_o.fetch_en = 1'b1;
            state_d        = bict_pkg::ST_MUL1;
          end else begin
            cmd_o.load_en = 1'b1;
          end
        end
      end
      bict_pkg::ST_MUL1: begin
        cmd_o.mul1_en = 1'b1;
        state_d       = bict_pkg::ST_MUL2;
      end
      bict_pkg::ST_MUL2: begin
        cmd_o.mul2_en = 1'b1;
        state_d       = bict_pkg::ST_MUL3;
      end
      bict_pkg::ST_MUL3: begin
        cmd_o.mul3_en = 1'b1;
        state_d       = bict_pkg::ST_SUM;
      end
      bict_pkg::ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = bict_pkg::ST_READ;
      end
      bict_pkg::ST_READ: begin
        cmd_o.read_en = 1'b1;
        state_d       = bict_pkg::ST_OUT;
      end
      bict_pkg::ST_OUT: begin
        // Hold the fetched byte until the output register is free.
        if (!status_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = bict_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bict_pkg::ST_IDLE;
      end
    endcase
  end

  `BICT_ASSERT_NEXT(a_fetch_starts_seq,
    in_fire && (in_command_i == bict_pkg::CMD_FETCH), state_q == bict_pkg::ST_MUL1)
  `BICT_ASSERT_NEXT(a_load_stays_idle,
    in_fire && (in_command_i == bict_pkg::CMD_LOAD), state_q == bict_pkg::ST_IDLE)
  `BICT_ASSERT_NEXT(a_out_wait_holds,
    (state_q == bict_pkg::ST_OUT) && status_i.out_full, state_q == bict_pkg::ST_OUT)

endmodule

>>> hw/rtl/bict_datapath.sv
`timescale 1ns / 1ps
`include "band_interleave_corner_turn_top_defines.svh"

module bict_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bict_pkg::dp_cmd_t                 cmd_i,
  output bict_pkg::dp_status_t              status_o,
  input  logic [bict_pkg::BYTE_W-1:0]       load_byte_i,
  bict_cfg_if.sink                          cfg_i,
  bict_out_if.source                        out_o
);

  // Configuration registers.
  logic [bict_pkg::BAND_W-1:0]  band_count_q;
  logic [bict_pkg::COUNT_W-1:0] spectra_count_q;
  logic [bict_pkg::POL_W-1:0]   pol_count_q;
  logic [bict_pkg::COUNT_W-1:0] chan_count_q;

  // Effective counts.
  logic [bict_pkg::BAND_W-1:0]  nb;
  logic [bict_pkg::COUNT_W-1:0] ns;
  logic [bict_pkg::POL_W-1:0]   np;
  logic [bict_pkg::COUNT_W-1:0] nc;

  // Frame position.
  logic [bict_pkg::WPOS_W-1:0] write_pos_q;
  logic [bict_pkg::IDX_W-1:0]  spec_idx_q;
  logic [bict_pkg::PIDX_W-1:0] pol_idx_q;
  logic [bict_pkg::BIDX_W-1:0] band_idx_q;
  logic [bict_pkg::IDX_W-1:0]  chan_idx_q;

  logic last_c, last_b, last_p, last_s, frame_end;
  logic wr_ok;

  // Fetch pipeline registers.
  logic [bict_pkg::IDX_W-1:0]   snap_spec_q;
  logic [bict_pkg::PIDX_W-1:0]  snap_pol_q;
  logic [bict_pkg::BIDX_W-1:0]  snap_band_q;
  logic [bict_pkg::IDX_W-1:0]   snap_chan_q;
  logic                         snap_last_q;
  logic [bict_pkg::SPEC_W-1:0]  per_spec_q;
  logic [bict_pkg::PTERM_W-1:0] pol_term_q;
  logic [bict_pkg::PBAND_W-1:0] per_band_q;
  logic [bict_pkg::PBAND_W-1:0] spec_term_q;
  logic [bict_pkg::SUM_W-1:0]   band_term_q;
  logic [bict_pkg::SUM_W-1:0]   addr_d, addr_q;
  logic                         ovf_q;

  logic [bict_pkg::BYTE_W-1:0]  rdata;

  // Output register.
  logic                        out_valid_q;
  logic [bict_pkg::BYTE_W-1:0] out_byte_q;
  logic                        out_last_q;
  logic                        out_ovf_q;

  assign cfg_i.ready = 1'b1;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_count_q    <= bict_pkg::BAND_W'(1);
      spectra_count_q <= bict_pkg::COUNT_W'(1);
      pol_count_q     <= bict_pkg::POL_W'(1);
      chan_count_q    <= bict_pkg::COUNT_W'(1);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        bict_pkg::CFG_BAND_COUNT:    band_count_q    <= cfg_i.data[bict_pkg::BAND_W-1:0];
        bict_pkg::CFG_SPECTRA_COUNT: spectra_count_q <= cfg_i.data;
        bict_pkg::CFG_POL_COUNT:     pol_count_q     <= cfg_i.data[bict_pkg::POL_W-1:0];
        bict_pkg::CFG_CHAN_COUNT:    chan_count_q    <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  assign nb = bict_pkg::clamp_band(band_count_q);
  assign ns = bict_pkg::clamp_count(spectra_count_q);
  assign np = bict_pkg::clamp_pol(pol_count_q);
  assign nc = bict_pkg::clamp_count(chan_count_q);

  // An index at or beyond its count minus one counts as last.
  assign last_c = (bict_pkg::COUNT_W'(chan_idx_q) + bict_pkg::COUNT_W'(1)) >= nc;
  assign last_b = (bict_pkg::BAND_W'(band_idx_q) + bict_pkg::BAND_W'(1)) >= nb;
  assign last_p = (bict_pkg::POL_W'(pol_idx_q) + bict_pkg::POL_W'(1)) >= np;
  assign last_s = (bict_pkg::COUNT_W'(spec_idx_q) + bict_pkg::COUNT_W'(1)) >= ns;
  assign frame_end = last_c && last_b && last_p && last_s;

  assign wr_ok = write_pos_q < bict_pkg::WPOS_W'(bict_pkg::BUF_BYTES);

  // Write position and read indices: channel fastest, then band, polarisation, spectrum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_pos_q <= '0;
      spec_idx_q  <= '0;
      pol_idx_q   <= '0;
      band_idx_q  <= '0;
      chan_idx_q  <= '0;
    end else if (cmd_i.load_en) begin
      if (wr_ok) begin
        write_pos_q <= write_pos_q + bict_pkg::WPOS_W'(1);
      end
    end else if (cmd_i.fetch_en) begin
      if (frame_end) begin
        write_pos_q <= '0;
        spec_idx_q  <= '0;
        pol_idx_q   <= '0;
        band_idx_q  <= '0;
        chan_idx_q  <= '0;
      end else if (!last_c) begin
        chan_idx_q <= chan_idx_q + bict_pkg::IDX_W'(1);
      end else begin
        chan_idx_q <= '0;
        if (!last_b) begin
          band_idx_q <= band_idx_q + bict_pkg::BIDX_W'(1);
        end else begin
          band_idx_q <= '0;
          if (!last_p) begin
            pol_idx_q <= pol_idx_q + bict_pkg::PIDX_W'(1);
          end else begin
            pol_idx_q  <= '0;
            spec_idx_q <= spec_idx_q + bict_pkg::IDX_W'(1);
          end
        end
      end
    end
  end

  // Address pipeline: one rank of multipliers per step, then the sum.
  assign addr_d = band_term_q
                + bict_pkg::SUM_W'(spec_term_q)
                + bict_pkg::SUM_W'(pol_term_q)
                + bict_pkg::SUM_W'(snap_chan_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch_en) begin
      snap_spec_q <= spec_idx_q;
      snap_pol_q  <= pol_idx_q;
      snap_band_q <= band_idx_q;
      snap_chan_q <= chan_idx_q;
      snap_last_q <= frame_end;
    end
    if (cmd_i.mul1_en) begin
      per_spec_q <= bict_pkg::SPEC_W'(np) * bict_pkg::SPEC_W'(nc);
      pol_term_q <= bict_pkg::PTERM_W'(snap_pol_q) * bict_pkg::PTERM_W'(nc);
    end
    if (cmd_i.mul2_en) begin
      per_band_q  <= bict_pkg::PBAND_W'(ns) * bict_pkg::PBAND_W'(per_spec_q);
      spec_term_q <= bict_pkg::PBAND_W'(snap_spec_q) * bict_pkg::PBAND_W'(per_spec_q);
    end
    if (cmd_i.mul3_en) begin
      band_term_q <= bict_pkg::SUM_W'(snap_band_q) * bict_pkg::SUM_W'(per_band_q);
    end
    if (cmd_i.sum_en) begin
      addr_q <= addr_d;
      ovf_q  <= addr_d >= bict_pkg::SUM_W'(bict_pkg::BUF_BYTES);
    end
  end

  // Frame store.
  bict_ram #(
    .WIDTH (bict_pkg::BYTE_W),
    .DEPTH (bict_pkg::BUF_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_en && wr_ok),
    .waddr_i (write_pos_q[bict_pkg::ADDR_W-1:0]),
    .wdata_i (load_byte_i),
    .re_i    (cmd_i.read_en && !ovf_q),
    .raddr_i (addr_q[bict_pkg::ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  // Output register; overflow forces the byte to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_byte_q <= ovf_q ? '0 : rdata;
      out_last_q <= snap_last_q;
      out_ovf_q  <= ovf_q;
    end
  end

  assign status_o.out_full = out_valid_q && !out_o.ready;

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_byte_q;
  assign out_o.frame_last = out_last_q;
  assign out_o.overflow   = out_ovf_q;

  `BICT_ASSERT_NOW(a_ovf_zero_byte, out_valid_q && out_ovf_q, out_byte_q == '0)
  `BICT_ASSERT_NOW(a_wpos_bound, 1'b1,
    write_pos_q <= bict_pkg::WPOS_W'(bict_pkg::BUF_BYTES))
  `BICT_ASSERT_NOW(a_no_overwrite, cmd_i.out_load, !(out_valid_q && !out_o.ready))

endmodule

>>> hw/rtl/band_interleave_corner_turn_top.sv
// Corner-turn buffer: loads append bytes, fetches return them in transposed order.
// A load leaves the sequencer idle, so the next item can be accepted in the following cycle.
// A fetch passes through three multiplier steps, an address sum, a store read and the
// output load before it presents its result and accepts the next item; the output
// load waits for as long as the output register is still full.
// Reset sets the counts to one and the positions to zero; the store is not cleared.
`timescale 1ns / 1ps

module band_interleave_corner_turn_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  bict_in_if.sink    in_i,
  bict_out_if.source out_o,
  bict_cfg_if.sink   cfg_i
);

  bict_pkg::dp_cmd_t    dp_cmd;
  bict_pkg::dp_status_t dp_status;
  logic                 in_ready;

  assign in_i.ready = in_ready;

  // Sequencer.
  bict_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_ready),
    .status_i     (dp_status),
    .cmd_o        (dp_cmd)
  );

  // Counters, address arithmetic, store and output register.
  bict_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .load_byte_i (in_i.load_byte),
    .cfg_i       (cfg_i),
    .out_o       (out_o)
  );

endmodule

>>> tb/bict_corner_turn_checker.sv
`timescale 1ns / 1ps

module bict_corner_turn_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  bict_in_if          in_w,
  bict_out_if         out_w,
  bict_cfg_if         cfg_w,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned loads_o,
  output int unsigned fetches_o,
  output int unsigned overflows_o,
  output int unsigned frame_ends_o
);

  // One predicted output beat.
  typedef struct packed {
    logic [bict_pkg::BYTE_W-1:0] value;
    logic                        last;
    logic                        ovf;
  } fetch_beat_t;

  // Shadow copy of the frame store, the positions and the count registers.
  logic [bict_pkg::BYTE_W-1:0]  frame_mem [bict_pkg::BUF_BYTES];
  logic [bict_pkg::WPOS_W-1:0]  wr_pos;
  logic [bict_pkg::IDX_W-1:0]   spec_idx;
  logic [bict_pkg::PIDX_W-1:0]  pol_idx;
  logic [bict_pkg::BIDX_W-1:0]  band_idx;
  logic [bict_pkg::IDX_W-1:0]   chan_idx;
  logic [bict_pkg::BAND_W-1:0]  band_reg;
  logic [bict_pkg::COUNT_W-1:0] spec_reg;
  logic [bict_pkg::POL_W-1:0]   pol_reg;
  logic [bict_pkg::COUNT_W-1:0] chan_reg;

  fetch_beat_t reordered_q[$];

  // A zero count behaves as one, and anything over the ceiling as the ceiling.
  function automatic int unsigned effective_count(input int unsigned raw,
                                                  input int unsigned ceiling);
    if (raw == 0) begin
      return 1;
    end
    return (raw > ceiling) ? ceiling : raw;
  endfunction

  // Work out the byte at the current output position, then step the read indices
  // with the channel fastest, then band, polarisation and spectrum.
  function automatic fetch_beat_t next_reordered_byte();
    int unsigned       nb;
    int unsigned       ns;
    int unsigned       np;
    int unsigned       nc;
    longint unsigned   per_spec;
    longint unsigned   per_band;
    longint unsigned   addr;
    logic              last_c;
    logic              last_b;
    logic              last_p;
    logic              last_s;
    fetch_beat_t       beat;
    nb       = effective_count(band_reg, 16);
    ns       = effective_count(spec_reg, 4096);
    np       = effective_count(pol_reg, 4);
    nc       = effective_count(chan_reg, 4096);
    per_spec = longint'(np) * nc;
    per_band = per_spec * ns;
    addr     = band_idx * per_band + spec_idx * per_spec + pol_idx * nc + chan_idx;

    beat.ovf   = (addr >= bict_pkg::BUF_BYTES);
    beat.value = beat.ovf ? '0 : frame_mem[addr[bict_pkg::ADDR_W-1:0]];

    // An index already at or past its count minus one counts as the last one.
    last_c    = (chan_idx + 1 >= nc);
    last_b    = (band_idx + 1 >= nb);
    last_p    = (pol_idx + 1 >= np);
    last_s    = (spec_idx + 1 >= ns);
    beat.last = last_c && last_b && last_p && last_s;

    if (beat.last) begin
      chan_idx = '0;
      band_idx = '0;
      pol_idx  = '0;
      spec_idx = '0;
      wr_pos   = '0;
    end else if (!last_c) begin
      chan_idx++;
    end else begin
      chan_idx = '0;
      if (!last_b) begin
        band_idx++;
      end else begin
        band_idx = '0;
        if (!last_p) begin
          pol_idx++;
        end else begin
          pol_idx = '0;
          spec_idx++;
        end
      end
    end
    return beat;
  endfunction

  task automatic check_field(input string name, input logic [bict_pkg::BYTE_W-1:0] want,
                             input logic [bict_pkg::BYTE_W-1:0] got);
    if (got !== want) begin
      errors_o++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Result beats are checked before new items are predicted, so a beat can never
  // meet an expectation queued at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    fetch_beat_t want;
    if (!rst_ni) begin
      wr_pos       = '0;
      spec_idx     = '0;
      pol_idx      = '0;
      band_idx     = '0;
      chan_idx     = '0;
      band_reg     = bict_pkg::BAND_W'(1);
      spec_reg     = bict_pkg::COUNT_W'(1);
      pol_reg      = bict_pkg::POL_W'(1);
      chan_reg     = bict_pkg::COUNT_W'(1);
      reordered_q.delete();
      errors_o     = 0;
      pending_o    = 0;
      loads_o      = 0;
      fetches_o    = 0;
      overflows_o  = 0;
      frame_ends_o = 0;
    end else begin
      if (out_w.valid && out_w.ready) begin
        if (reordered_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result beat, expected none, got byte %0h last %0b ovf %0b",
                   $time, out_w.out_byte, out_w.frame_last, out_w.overflow);
        end else begin
          want = reordered_q.pop_front();
          check_field("out_byte", want.value, out_w.out_byte);
          check_field("frame_last", bict_pkg::BYTE_W'(want.last),
                      bict_pkg::BYTE_W'(out_w.frame_last));
          check_field("overflow", bict_pkg::BYTE_W'(want.ovf),
                      bict_pkg::BYTE_W'(out_w.overflow));
        end
      end

      // Register writes keep only the bits that each count holds.
      if (cfg_w.valid && cfg_w.ready) begin
        case (cfg_w.index)
          bict_pkg::CFG_BAND_COUNT:    band_reg = cfg_w.data[bict_pkg::BAND_W-1:0];
          bict_pkg::CFG_SPECTRA_COUNT: spec_reg = cfg_w.data[bict_pkg::COUNT_W-1:0];
          bict_pkg::CFG_POL_COUNT:     pol_reg  = cfg_w.data[bict_pkg::POL_W-1:0];
          bict_pkg::CFG_CHAN_COUNT:    chan_reg = cfg_w.data[bict_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end

      // A load appends unless the buffer is full; a fetch queues one expected beat.
      if (in_w.valid && in_w.ready) begin
        if (in_w.command == bict_pkg::CMD_LOAD) begin
          loads_o++;
          if (wr_pos < bict_pkg::BUF_BYTES) begin
            frame_mem[wr_pos[bict_pkg::ADDR_W-1:0]] = in_w.load_byte;
            wr_pos++;
          end
        end else begin
          want = next_reordered_byte();
          reordered_q.push_back(want);
          fetches_o++;
          if (want.ovf) begin
            overflows_o++;
          end
          if (want.last) begin
            frame_ends_o++;
          end
        end
      end
      pending_o = reordered_q.size();
    end
  end

endmodule

>>> tb/tb_band_interleave_corner_turn_top.sv
`timescale 1ns / 1ps

module tb_band_interleave_corner_turn_top;

  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int unsigned PRELOAD_BYTES = 512;
  localparam int unsigned RANDOM_ITEMS  = 900;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned DRAIN_CYCLES  = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned item_cnt = 0;
  int unsigned tx_idle_pct = 10;
  int unsigned rx_idle_pct = 47;

  int unsigned fail_cnt;
  int unsigned outstanding;
  int unsigned loads_seen;
  int unsigned fetches_seen;
  int unsigned overflow_cnt;
  int unsigned frame_end_cnt;

  bict_in_if  in_w ();
  bict_out_if out_w ();
  bict_cfg_if cfg_w ();

  band_interleave_corner_turn_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w),
    .cfg_i  (cfg_w)
  );

  bict_corner_turn_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_w         (in_w),
    .out_w        (out_w),
    .cfg_w        (cfg_w),
    .errors_o     (fail_cnt),
    .pending_o    (outstanding),
    .loads_o      (loads_seen),
    .fetches_o    (fetches_seen),
    .overflows_o  (overflow_cnt),
    .frame_ends_o (frame_end_cnt)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_cnt, outstanding);
      $display("simulation failed");
      $finish;
    end
  end

  // The receiver stalls at random, at the rate of the current idling phase.
  always @(negedge clk_i) begin
    out_w.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // A zero count behaves as one, and anything over the ceiling as the ceiling.
  function automatic int unsigned eff_count(input int unsigned raw,
                                            input int unsigned ceiling);
    if (raw == 0) begin
      return 1;
    end
    return (raw > ceiling) ? ceiling : raw;
  endfunction

  // Offers one item from a falling edge and returns at the falling edge after its
  // beat, leaving valid high so that the next item can follow without a gap.
  task automatic put_item(input logic cmd, input logic [bict_pkg::BYTE_W-1:0] data);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_w.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_w.valid     <= 1'b1;
    in_w.command   <= cmd;
    in_w.load_byte <= data;
    @(posedge clk_i);
    while (!in_w.ready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    item_cnt++;
  endtask

  task automatic write_reg(input bict_pkg::cfg_reg_e idx,
                           input logic [bict_pkg::CFG_DAT_W-1:0] value);
    cfg_w.valid <= 1'b1;
    cfg_w.index <= idx;
    cfg_w.data  <= value;
    @(posedge clk_i);
    while (!cfg_w.ready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  task automatic set_counts(input logic [bict_pkg::CFG_DAT_W-1:0] bands,
                            input logic [bict_pkg::CFG_DAT_W-1:0] spectra,
                            input logic [bict_pkg::CFG_DAT_W-1:0] pols,
                            input logic [bict_pkg::CFG_DAT_W-1:0] chans);
    write_reg(bict_pkg::CFG_BAND_COUNT, bands);
    write_reg(bict_pkg::CFG_SPECTRA_COUNT, spectra);
    write_reg(bict_pkg::CFG_POL_COUNT, pols);
    write_reg(bict_pkg::CFG_CHAN_COUNT, chans);
    cfg_w.valid <= 1'b0;
  endtask

  // Waits until every expected beat is back, then leaves room for a load that
  // may still be in flight before the registers are touched.
  task automatic settle();
    in_w.valid <= 1'b0;
    while (outstanding != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic load_bytes(input int unsigned n);
    repeat (n) put_item(bict_pkg::CMD_LOAD, bict_pkg::BYTE_W'($urandom_range(255)));
  endtask

  task automatic fetch_n(input int unsigned n);
    repeat (n) put_item(bict_pkg::CMD_FETCH, bict_pkg::BYTE_W'($urandom_range(255)));
  endtask

  // Fetches until a frame end has been predicted, mixing in stray loads.
  task automatic fetch_to_frame_end(input int unsigned load_pct);
    int unsigned start;
    start = frame_end_cnt;
    while (frame_end_cnt == start) begin
      put_item(($urandom_range(99) < load_pct) ? bict_pkg::CMD_LOAD : bict_pkg::CMD_FETCH,
               bict_pkg::BYTE_W'($urandom_range(255)));
    end
  endtask

  initial begin
    int unsigned base;
    int unsigned done;
    int unsigned roll;
    int unsigned bands;
    int unsigned spectra;
    int unsigned pols;
    int unsigned chans;
    int unsigned frame_bytes;
    int unsigned band_bytes;
    int unsigned fetches;
    in_w.valid     = 1'b0;
    in_w.command   = bict_pkg::CMD_LOAD;
    in_w.load_byte = '0;
    cfg_w.valid    = 1'b0;
    cfg_w.index    = bict_pkg::CFG_BAND_COUNT;
    cfg_w.data     = '0;
    out_w.ready    = 1'b0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Write the start of the store so that no later fetch meets an entry left
    // unknown by reset; every later fetch lies below this or beyond the buffer.
    load_bytes(PRELOAD_BYTES);
    // With every count at one, a fetch returns entry zero and closes the frame.
    fetch_n(1);
    settle();

    // Counts above their ceilings: a band then spans the whole buffer, so every
    // band after the first lies beyond it.
    set_counts(13'd31, 13'd8191, 13'd7, 13'd4);
    fetch_n(20);
    settle();
    // All counts zero now, under indices already past them: the next fetch ends it.
    set_counts(13'd0, 13'd0, 13'd0, 13'd0);
    fetch_to_frame_end(0);
    settle();

    // Widest channel count with the extreme byte values.
    set_counts(13'd1, 13'd2, 13'd1, 13'd4096);
    put_item(bict_pkg::CMD_LOAD, 8'h00);
    put_item(bict_pkg::CMD_LOAD, 8'hFF);
    put_item(bict_pkg::CMD_LOAD, 8'hA5);
    fetch_n(3);
    settle();
    set_counts(13'd1, 13'd1, 13'd1, 13'd8191);
    fetch_n(2);
    settle();
    // The channel count drops below the channel index in the middle of a frame.
    set_counts(13'd1, 13'd1, 13'd4, 13'd2);
    fetch_to_frame_end(0);
    settle();

    // A small complete frame.
    set_counts(13'd2, 13'd1, 13'd2, 13'd2);
    load_bytes(8);
    fetch_to_frame_end(0);

    // Random frames, mostly well formed, with stray loads, broken frames and
    // count changes part way through a frame.
    base = item_cnt;
    while (item_cnt - base < RANDOM_ITEMS) begin
      done = item_cnt - base;
      if (done >= 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (done >= RANDOM_ITEMS / 3) begin
        tx_idle_pct = 47;
        rx_idle_pct = 10;
      end
      roll = $urandom_range(99);
      settle();
      if (roll < 70) begin
        bands   = $urandom_range(1, 4);
        spectra = $urandom_range(1, 3);
        pols    = $urandom_range(1, 4);
        chans   = $urandom_range(1, 6);
        set_counts(bict_pkg::CFG_DAT_W'(bands), bict_pkg::CFG_DAT_W'(spectra),
                   bict_pkg::CFG_DAT_W'(pols), bict_pkg::CFG_DAT_W'(chans));
        frame_bytes = bands * spectra * pols * chans;
        load_bytes((roll < 10) ? $urandom_range(frame_bytes + 3) : frame_bytes);
        fetch_to_frame_end((roll < 20) ? 5 : 0);
      end else if (roll < 90) begin
        bands   = $urandom_range(8191);
        spectra = $urandom_range(8191);
        pols    = $urandom_range(8191);
        chans   = $urandom_range(8191);
        set_counts(bict_pkg::CFG_DAT_W'(bands), bict_pkg::CFG_DAT_W'(spectra),
                   bict_pkg::CFG_DAT_W'(pols), bict_pkg::CFG_DAT_W'(chans));
        load_bytes($urandom_range(8));
        // Stay inside the first band unless a band spans the whole buffer, so
        // that a band step never lands on an entry that was never loaded.
        fetches    = $urandom_range(1, 12);
        band_bytes = eff_count(spectra, 4096) * eff_count(pols & 7, 4)
                   * eff_count(chans, 4096);
        if (band_bytes < bict_pkg::BUF_BYTES && fetches > eff_count(chans, 4096)) begin
          fetches = eff_count(chans, 4096);
        end
        fetch_n(fetches);
        settle();
        set_counts(bict_pkg::CFG_DAT_W'($urandom_range(1, 3)),
                   bict_pkg::CFG_DAT_W'($urandom_range(1, 2)),
                   bict_pkg::CFG_DAT_W'($urandom_range(1, 4)),
                   bict_pkg::CFG_DAT_W'($urandom_range(1, 4)));
        fetch_to_frame_end(5);
      end else begin
        repeat ($urandom_range(4, 12)) begin
          put_item(1'($urandom_range(1)), bict_pkg::BYTE_W'($urandom_range(255)));
        end
        fetch_to_frame_end(0);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Checked %0d fetched bytes (%0d beyond the buffer, %0d frame ends) after %0d loads.",
             fetches_seen, overflow_cnt, frame_end_cnt, loads_seen);
    $display("Counts ran from zero to past their ceilings, with mid-frame changes and stray loads.");
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
